>>> hw/rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

  // Field widths.
  localparam int unsigned ChanW   = 8;   // one color channel, saturation, brightness
  localparam int unsigned HueW    = 9;   // hue in whole degrees
  localparam int unsigned ProdW   = 16;  // chroma and offset, units of 1/65025
  localparam int unsigned DistW   = 6;   // distance of hue mod 120 from 60
  localparam int unsigned SectW   = 3;   // color wheel sector
  localparam int unsigned ScaledW = 22;  // channel values at 60 times scale

  localparam logic [ChanW-1:0] BrightReset = 8'd255;
  localparam logic [DistW-1:0] HalfSector  = 6'd60;

  // The final division by 15300 is a shift by two and then a division by 3825,
  // done as a multiplication by a rounded-up reciprocal of 2^32 / 3825.
  localparam int unsigned QuotW      = ScaledW - 2;
  localparam int unsigned RecipW     = 21;
  localparam int unsigned RecipShift = 32;
  localparam logic [RecipW-1:0] Recip3825 = 21'd1122868;

  // Color wheel sectors, in order of hue.
  localparam logic [SectW-1:0] SectRedYellow    = 3'd0;
  localparam logic [SectW-1:0] SectYellowGreen  = 3'd1;
  localparam logic [SectW-1:0] SectGreenCyan    = 3'd2;
  localparam logic [SectW-1:0] SectCyanBlue     = 3'd3;
  localparam logic [SectW-1:0] SectBlueMagenta  = 3'd4;
  localparam logic [SectW-1:0] SectMagentaRed   = 3'd5;

  typedef struct packed {
    logic [ProdW-1:0] chroma;
    logic [ProdW-1:0] offset;
    logic [DistW-1:0] hue_dist;
    logic [SectW-1:0] sector;
  } prep_t;

  typedef struct packed {
    logic [ScaledW-1:0] c60;
    logic [ScaledW-1:0] x60;
    logic [ScaledW-1:0] m60;
    logic [SectW-1:0]   sector;
  } scale_t;

  typedef struct packed {
    logic [ScaledW-1:0] red;
    logic [ScaledW-1:0] green;
    logic [ScaledW-1:0] blue;
  } mix_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsv2rgb_prep.sv
`default_nettype none

module hsv2rgb_prep (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                valid_i,
  input  wire  [hsv2rgb_pkg::HueW-1:0]       hue_i,
  input  wire  [hsv2rgb_pkg::ChanW-1:0]      saturation_i,
  input  wire  [hsv2rgb_pkg::ChanW-1:0]      brightness_i,
  output hsv2rgb_pkg::prep_t                 prep_o
);
  import hsv2rgb_pkg::*;

  localparam logic [HueW-1:0] Deg60  = 9'd60;
  localparam logic [HueW-1:0] Deg120 = 9'd120;
  localparam logic [HueW-1:0] Deg180 = 9'd180;
  localparam logic [HueW-1:0] Deg240 = 9'd240;
  localparam logic [HueW-1:0] Deg300 = 9'd300;
  localparam logic [HueW-1:0] Deg360 = 9'd360;
  localparam logic [HueW-1:0] Deg480 = 9'd480;

  logic [HueW-1:0]  base;
  logic [6:0]       rem;
  logic [6:0]       dist_wide;
  logic [SectW-1:0] sector;
  logic [ProdW-1:0] chroma;
  logic [ProdW-1:0] full;
  prep_t            prep_d, prep_q;

  always_comb begin
    if (hue_i < Deg120) begin
      base = '0;
    end else if (hue_i < Deg240) begin
      base = Deg120;
    end else if (hue_i < Deg360) begin
      base = Deg240;
    end else if (hue_i < Deg480) begin
      base = Deg360;
    end else begin
      base = Deg480;
    end

    if (hue_i < Deg60) begin
      sector = SectRedYellow;
    end else if (hue_i < Deg120) begin
      sector = SectYellowGreen;
    end else if (hue_i < Deg180) begin
      sector = SectGreenCyan;
    end else if (hue_i < Deg240) begin
      sector = SectCyanBlue;
    end else if (hue_i < Deg300) begin
      sector = SectBlueMagenta;
    end else begin
      sector = SectMagentaRed;
    end
  end

  assign rem       = 7'(hue_i - base);
  assign dist_wide = (rem >= 7'(HalfSector)) ? (rem - 7'(HalfSector))
                                             : (7'(HalfSector) - rem);
  assign chroma    = ProdW'(brightness_i) * ProdW'(saturation_i);
  // Brightness times 255, the value of a fully lit gray.
  assign full      = {brightness_i, 8'd0} - ProdW'(brightness_i);

  always_comb begin
    prep_d.chroma   = chroma;
    prep_d.offset   = full - chroma;
    prep_d.hue_dist = dist_wide[DistW-1:0];
    prep_d.sector   = sector;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_i) |-> (prep_q.hue_dist <= HalfSector && prep_q.sector <= SectMagentaRed))
    else $error("hue distance or sector out of range");

endmodule

`default_nettype wire

>>> hw/rtl/hsv2rgb_scale.sv
`default_nettype none

module hsv2rgb_scale (
  input  wire                  clk_i,
  input  wire                  valid_i,
  input  hsv2rgb_pkg::prep_t   prep_i,
  output hsv2rgb_pkg::scale_t  scale_o
);
  import hsv2rgb_pkg::*;

  scale_t scale_d, scale_q;

  always_comb begin
    scale_d.c60    = ScaledW'(prep_i.chroma) * ScaledW'(HalfSector);
    scale_d.x60    = ScaledW'(prep_i.chroma) * ScaledW'(HalfSector - prep_i.hue_dist);
    scale_d.m60    = ScaledW'(prep_i.offset) * ScaledW'(HalfSector);
    scale_d.sector = prep_i.sector;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      scale_q <= scale_d;
    end
  end

  assign scale_o = scale_q;

endmodule

`default_nettype wire

>>> hw/rtl/hsv2rgb_mix.sv
`default_nettype none

module hsv2rgb_mix (
  input  wire                  clk_i,
  input  wire                  valid_i,
  input  hsv2rgb_pkg::scale_t  scale_i,
  output hsv2rgb_pkg::mix_t    mix_o
);
  import hsv2rgb_pkg::*;

  logic [ScaledW-1:0] r, g, b;
  mix_t               mix_d, mix_q;

  always_comb begin
    case (scale_i.sector)
      SectRedYellow: begin
        r = scale_i.c60; g = scale_i.x60; b = '0;
      end
      SectYellowGreen: begin
        r = scale_i.x60; g = scale_i.c60; b = '0;
      end
      SectGreenCyan: begin
        r = '0; g = scale_i.c60; b = scale_i.x60;
      end
      SectCyanBlue: begin
        r = '0; g = scale_i.x60; b = scale_i.c60;
      end
      SectBlueMagenta: begin
        r = scale_i.x60; g = '0; b = scale_i.c60;
      end
      default: begin
        r = scale_i.c60; g = '0; b = scale_i.x60;
      end
    endcase
    mix_d.red   = r + scale_i.m60;
    mix_d.green = g + scale_i.m60;
    mix_d.blue  = b + scale_i.m60;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

`default_nettype wire

>>> hw/rtl/hsv2rgb_div.sv
`default_nettype none

module hsv2rgb_div (
  input  wire                                clk_i,
  input  wire                                valid_i,
  input  wire  [hsv2rgb_pkg::ScaledW-1:0]    num_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]      quot_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned FullW = QuotW + RecipW;

  logic [FullW-1:0] prod;
  logic [ChanW-1:0] quot_q;

  // The quotient never exceeds 255, so the bits above the channel are zero.
  assign prod = FullW'(num_i[ScaledW-1:2]) * FullW'(Recip3825);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      quot_q <= prod[RecipShift +: ChanW];
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/hsv_to_rgb_color_unit.sv
// HSV to RGB converter, four register stages deep.
// An accepted word passes through the prep, scale, mix and divide registers to the
// result ports, where valid_o marks it.
// Throughput: one word per cycle; busy is never raised and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears the stage valid bits and sets brightness to 255.
// Configuration writes are always ready and take effect for words accepted afterwards.
`default_nettype none

module hsv_to_rgb_color_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration write channel: brightness.
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [hsv2rgb_pkg::ChanW-1:0]      cfg_data_i,
  // Command side.
  input  wire                                start,
  output logic                               busy,
  input  wire  [hsv2rgb_pkg::HueW-1:0]       hue_i,
  input  wire  [hsv2rgb_pkg::ChanW-1:0]      saturation_i,
  // Result side, one strobe per word.
  output logic                               valid_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]      red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]      green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]      blue_o
);
  import hsv2rgb_pkg::*;

  // The pipeline moves every cycle, so it never has to refuse a word.
  logic             accept;
  logic [ChanW-1:0] bright_q;
  logic [3:0]       valid_q, valid_d;
  prep_t            prep;
  scale_t           scale;
  mix_t             mix;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Brightness register. The user must only rewrite it while no word is in flight; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BrightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bright_q <= cfg_data_i;
    end
  end

  // One valid bit per stage travels alongside the data.
  assign valid_d = {valid_q[2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: chroma, gray offset, distance from the sector middle and sector.
  hsv2rgb_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (bright_q),
    .prep_o       (prep)
  );

  // Stage 2: everything is scaled by 60 so the secondary component stays exact.
  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .valid_i (valid_q[0]),
    .prep_i  (prep),
    .scale_o (scale)
  );

  // Stage 3: the sector routes the components to channels, and the offset is added.
  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .valid_i (valid_q[1]),
    .scale_i (scale),
    .mix_o   (mix)
  );

  // Stage 4: each channel is divided by 15300 and truncated.
  hsv2rgb_div u_div_red (
    .clk_i   (clk_i),
    .valid_i (valid_q[2]),
    .num_i   (mix.red),
    .quot_o  (red_o)
  );

  hsv2rgb_div u_div_green (
    .clk_i   (clk_i),
    .valid_i (valid_q[2]),
    .num_i   (mix.green),
    .quot_o  (green_o)
  );

  hsv2rgb_div u_div_blue (
    .clk_i   (clk_i),
    .valid_i (valid_q[2]),
    .num_i   (mix.blue),
    .quot_o  (blue_o)
  );

  assign valid_o = valid_q[3];

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##4 !valid_o)
    else $error("result strobe without an accepted word");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised on a pipeline that never stalls");

endmodule

`default_nettype wire

>>> tb/tb_hsv_to_rgb_color_unit.sv
`default_nettype none

module tb_hsv_to_rgb_color_unit;
  import hsv2rgb_pkg::*;

  // SettleCycles gives the pipeline ample quiet time to empty before a brightness
  // write or before the final verdict.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomWords  = 650;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned ScaleDen     = 15300;

  // One entry of the stimulus plan. The driver works through these in order.
  typedef enum logic [1:0] {
    StepWord,    // offer one hue/saturation word
    StepIdle,    // hold start low for a number of cycles
    StepDrain,   // wait until every expected pixel has come back
    StepBright   // write the brightness register
  } step_kind_e;

  typedef struct {
    step_kind_e        kind;
    logic [HueW-1:0]   hue;
    logic [ChanW-1:0]  sat;
    logic [ChanW-1:0]  level;
    int unsigned       count;
  } plan_step_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // Every block input has a known value from time zero.
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic [ChanW-1:0] cfg_data_i   = '0;
  logic             start        = 1'b0;
  logic             busy;
  logic [HueW-1:0]  hue_i        = '0;
  logic [ChanW-1:0] saturation_i = '0;
  logic             valid_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  plan_step_t       pixel_plan[$];
  rgb_t             rgb_due[$];
  logic [ChanW-1:0] level_model = BrightReset;
  int unsigned      failures    = 0;
  int unsigned      cycle_count = 0;

  // Driver bookkeeping. The monitor counts what the block took, the driver
  // counts what it offered; when the two agree the offer has been taken.
  int unsigned      words_sent  = 0;
  int unsigned      words_taken = 0;
  int unsigned      cfg_sent    = 0;
  int unsigned      cfg_taken   = 0;
  bit               offer_word  = 1'b0;
  bit               offer_level = 1'b0;
  int unsigned      idle_left   = 0;
  logic [HueW-1:0]  word_hue    = '0;
  logic [ChanW-1:0] word_sat    = '0;
  logic [ChanW-1:0] level_out   = '0;

  hsv_to_rgb_color_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always #5 clk_i = ~clk_i;

  // Exact fixed-point conversion. Chroma and offset are in units of 1/65025,
  // and each channel is built at 60 times scale so that the second color
  // component X is never truncated on its own; only the final division by
  // 60 * 255 truncates.
  function automatic rgb_t rgb_of_hsv(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                                      logic [ChanW-1:0] level);
    int unsigned      chroma;
    int unsigned      offset;
    int unsigned      rem;
    int unsigned      hue_dist;
    int unsigned      c60;
    int unsigned      x60;
    int unsigned      m60;
    int unsigned      r;
    int unsigned      g;
    int unsigned      b;
    logic [SectW-1:0] sector;
    rgb_t             px;
    chroma   = int'(level) * int'(sat);
    offset   = int'(level) * 255 - chroma;
    rem      = int'(hue) % 120;
    hue_dist = (rem >= 60) ? rem - 60 : 60 - rem;
    c60      = chroma * 60;
    x60      = chroma * (60 - hue_dist);
    m60      = offset * 60;
    // Hues past 359 do not wrap: they stay in the last sector.
    if (hue >= 9'd300) begin
      sector = SectMagentaRed;
    end else begin
      sector = SectW'(int'(hue) / 60);
    end
    case (sector)
      SectRedYellow: begin
        r = c60; g = x60; b = 0;
      end
      SectYellowGreen: begin
        r = x60; g = c60; b = 0;
      end
      SectGreenCyan: begin
        r = 0; g = c60; b = x60;
      end
      SectCyanBlue: begin
        r = 0; g = x60; b = c60;
      end
      SectBlueMagenta: begin
        r = x60; g = 0; b = c60;
      end
      default: begin
        r = c60; g = 0; b = x60;
      end
    endcase
    px.red   = ChanW'((r + m60) / ScaleDen);
    px.green = ChanW'((g + m60) / ScaleDen);
    px.blue  = ChanW'((b + m60) / ScaleDen);
    return px;
  endfunction

  function automatic plan_step_t mk_step(step_kind_e kind, int unsigned hue, int unsigned sat,
                                         int unsigned level, int unsigned count);
    plan_step_t step;
    step.kind  = kind;
    step.hue   = HueW'(hue);
    step.sat   = ChanW'(sat);
    step.level = ChanW'(level);
    step.count = count;
    return step;
  endfunction

  // Appends one entry at the tail of the stimulus plan.
  task automatic plan_add(plan_step_t step);
    pixel_plan = {pixel_plan, step};
  endtask

  task automatic check_chan(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Random pause before a word: most words follow at once, some after a short
  // gap and a few after a long one. In dense stretches there is no gap at all.
  task automatic plan_gap(bit dense);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!dense && roll >= 55) begin
      if (roll < 92) begin
        plan_add(mk_step(StepIdle, 0, 0, 0, $urandom_range(1, 3)));
      end else begin
        plan_add(mk_step(StepIdle, 0, 0, 0, $urandom_range(10, 40)));
      end
    end
  endtask

  // A brightness write only goes in once the pipeline has emptied, so that
  // no word in flight could see either setting.
  task automatic plan_level(int unsigned level);
    plan_add(mk_step(StepDrain, 0, 0, 0, 0));
    plan_add(mk_step(StepBright, 0, 0, level, 0));
  endtask

  task automatic plan_random_word(bit dense);
    int unsigned roll;
    int unsigned hue;
    int unsigned sat;
    roll = $urandom_range(0, 99);
    // Most hues are legal degrees; the rest land past 359 where the sector
    // saturates, which also exercises the top hue bit.
    hue = (roll < 88) ? $urandom_range(0, 359) : $urandom_range(360, 511);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      sat = 0;
    end else if (roll < 12) begin
      sat = 255;
    end else begin
      sat = $urandom_range(0, 255);
    end
    plan_gap(dense);
    plan_add(mk_step(StepWord, hue, sat, 0, 0));
  endtask

  // Monitor: checks each result strobe against the oldest expectation, then
  // records what the block took on its command and configuration ports at
  // this same edge. Checking first keeps a word taken now from ever being
  // matched against a result that shows up at the same edge.
  always @(posedge clk_i) begin : monitor
    rgb_t want;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (rgb_due.size() == 0) begin
          $error("unexpected result word: red %0d green %0d blue %0d", red_o, green_o, blue_o);
          failures++;
        end else begin
          want = rgb_due.pop_front();
          check_chan("red", want.red, red_o);
          check_chan("green", want.green, green_o);
          check_chan("blue", want.blue, blue_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o === 1'b1) begin
        level_model = cfg_data_i;
        cfg_taken++;
      end
      if (start && busy === 1'b0) begin
        rgb_due = {rgb_due, rgb_of_hsv(hue_i, saturation_i, level_model)};
        words_taken++;
      end
    end
  end

  // Driver: works at the falling edge. An offer stays up until the monitor has
  // seen it taken; the next plan entry may then go out in the same half cycle,
  // so back-to-back words keep start high without a dip.
  always @(negedge clk_i) begin : driver
    plan_step_t step;
    if (rst_ni) begin
      if (offer_word && words_taken == words_sent) begin
        offer_word = 1'b0;
      end
      if (offer_level && cfg_taken == cfg_sent) begin
        offer_level = 1'b0;
      end
      if (!offer_word && !offer_level) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pixel_plan.size() > 0) begin
          step = pixel_plan[0];
          case (step.kind)
            StepIdle: begin
              void'(pixel_plan.pop_front());
              idle_left = step.count - 1;
            end
            StepDrain: begin
              if (rgb_due.size() == 0) begin
                void'(pixel_plan.pop_front());
                idle_left = SettleCycles;
              end
            end
            StepBright: begin
              void'(pixel_plan.pop_front());
              level_out   = step.level;
              offer_level = 1'b1;
              cfg_sent++;
            end
            default: begin
              void'(pixel_plan.pop_front());
              word_hue   = step.hue;
              word_sat   = step.sat;
              offer_word = 1'b1;
              words_sent++;
            end
          endcase
        end
      end
    end
    // Idle data lines carry noise; the block must ignore them.
    start        <= offer_word;
    hue_i        <= offer_word ? word_hue : HueW'($urandom);
    saturation_i <= offer_word ? word_sat : ChanW'($urandom);
    cfg_valid_i  <= offer_level;
    cfg_data_i   <= offer_level ? level_out : ChanW'($urandom);
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned edge_hues[20];
    int unsigned levels[NumPhases];
    int unsigned per_phase;
    bit          dense;

    edge_hues = '{0, 30, 59, 60, 90, 119, 120, 150, 179, 180,
                  210, 239, 240, 270, 299, 300, 330, 359, 360, 511};

    // Directed words at the reset brightness: both sides of every sector
    // boundary with full saturation, the hue wrap point and the top of the
    // hue field, then gray (no saturation) and a couple of partial values.
    foreach (edge_hues[i]) begin
      plan_add(mk_step(StepWord, edge_hues[i], 255, 0, 0));
    end
    plan_add(mk_step(StepWord, 0, 0, 0, 0));
    plan_add(mk_step(StepWord, 200, 128, 0, 0));
    plan_add(mk_step(StepWord, 45, 1, 0, 0));

    // Brightness settings: black, the smallest step, mid, just below full,
    // full, and two random ones.
    levels[0] = 0;
    levels[1] = 1;
    levels[2] = 128;
    levels[3] = 254;
    levels[4] = $urandom_range(2, 253);
    levels[5] = 255;
    levels[6] = $urandom_range(2, 253);
    per_phase = RandomWords / NumPhases;

    for (int p = 0; p < NumPhases; p++) begin
      plan_level(levels[p]);
      plan_add(mk_step(StepWord, 0, 255, 0, 0));
      plan_add(mk_step(StepWord, 511, 0, 0, 0));
      dense = 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        // Switch between gapped and gap-free stretches every so often.
        if (n % 20 == 0) begin
          dense = ($urandom_range(0, 3) == 0);
        end
        // Halfway through one phase the sender stops until the block has
        // delivered every pending pixel.
        if (p == 2 && n == per_phase / 2) begin
          plan_add(mk_step(StepDrain, 0, 0, 0, 0));
        end
        plan_random_word(dense);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_plan.size() != 0 || offer_word || offer_level || rgb_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
